FILE: src/bchm_pkg.sv
// shared types and constants of the border colour histogram mode block
package bchm_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int REG_INDEX_W  = 3;
    localparam int REG_DATA_W   = 16;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_THICKNESS = 3'd0,
        REG_EXPONENT  = 3'd1,
        REG_LEFT      = 3'd2,
        REG_TOP       = 3'd3,
        REG_RIGHT     = 3'd4,
        REG_BOTTOM    = 3'd5,
        REG_CHANNELS  = 3'd6
    } reg_index_t;

    localparam logic [15:0] THICKNESS_RESET = 16'd3;
    localparam logic [3:0]  EXPONENT_RESET  = 4'd4;
    localparam logic [2:0]  CHANNELS_RESET  = 3'd3;

    // live configuration, already clamped and masked
    typedef struct packed {
        logic [15:0] thickness;
        logic [15:0] left_edge;
        logic [15:0] top_edge;
        logic [15:0] right_end;
        logic [15:0] bottom_end;
        logic [3:0]  exponent;
        logic [3:0]  level_bits;
        logic        use_green;
        logic        use_blue;
    } cfg_t;

endpackage

FILE: src/border_color_histogram_mode.sv
// top level: stream ports, configuration port and result register
//
// Pixels stream in one per cycle on the s_ side while s_tready is high; each is
// read from the histogram memory on acceptance and, if it lies in the border
// band, its incremented count is written back the next cycle, with the previous
// write forwarded when two pixels land in the same cell. A pixel with tlast set
// is counted likewise, then s_tready stays low while the sweep reads and zeroes
// every entry of the cube, finding the first largest count. The result, the
// winning bucket's centre colour and its count (all zero if nothing was counted),
// is then offered on the m_ side from a register, and pixels are taken again
// while it waits. After reset the cube is cleared entry by entry before the
// first pixel is accepted; configuration writes are taken at any time but must
// only be made while the block is idle.
module border_color_histogram_mode
    import bchm_pkg::*;
#(
    parameter int LEVEL_BITS  = 4,
    parameter int COUNT_WIDTH = 24,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [55:0]            s_tdata,   // pixel_x, pixel_y, red_in, green_in, blue_in
    input  logic                   s_tlast,   // last_pixel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,   // red_out, green_out, blue_out, peak_count
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [REG_DATA_W-1:0]  cfg_data
);

    localparam int CELL_BITS = 3 * (CHANNEL_BITS - LEVEL_BITS);
    localparam int ADDR_W    = (CELL_BITS > 0) ? CELL_BITS : 1;

    cfg_t                   cfg;
    logic                   px_hit;
    logic [ADDR_W-1:0]      px_cell;
    logic                   res_valid;
    logic                   res_ready;
    logic [COUNT_WIDTH-1:0] res_count;
    logic [ADDR_W-1:0]      res_index;
    logic [3:0]             res_exponent;
    logic [3:0]             res_level_bits;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [47:0]            m_tdata_reg;
    logic [47:0]            m_tdata_next;

    logic [23:0] idx_full;
    logic [7:0]  level_mask;
    logic [7:0]  lvl_r;
    logic [7:0]  lvl_g;
    logic [7:0]  lvl_b;
    logic [7:0]  half_step;
    logic [7:0]  ctr_r;
    logic [7:0]  ctr_g;
    logic [7:0]  ctr_b;

    assign cfg_ready = 1'b1;

    bchm_regs #(
        .LEVEL_BITS  (LEVEL_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bchm_binner #(
        .LEVEL_BITS  (LEVEL_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_binner (
        .cfg       (cfg),
        .pixel_x   (s_tdata[15:0]),
        .pixel_y   (s_tdata[31:16]),
        .red_in    (s_tdata[39:32]),
        .green_in  (s_tdata[47:40]),
        .blue_in   (s_tdata[55:48]),
        .hit       (px_hit),
        .cell_addr (px_cell)
    );

    bchm_cube #(
        .LEVEL_BITS  (LEVEL_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cube (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .px_valid       (s_tvalid),
        .px_ready       (s_tready),
        .px_hit         (px_hit),
        .px_last        (s_tlast),
        .px_cell        (px_cell),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_count      (res_count),
        .res_index      (res_index),
        .res_exponent   (res_exponent),
        .res_level_bits (res_level_bits)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    // bucket centre: level shifted up by the exponent plus half a bucket
    always_comb
    begin
        idx_full   = 24'(res_index);
        level_mask = 8'((16'd1 << res_level_bits) - 16'd1);
        lvl_r = 8'(idx_full >> {res_level_bits, 1'b0}) & level_mask;
        lvl_g = 8'(idx_full >> res_level_bits) & level_mask;
        lvl_b = 8'(idx_full) & level_mask;
        half_step = 8'(16'd1 << (res_exponent - 4'd1));
        ctr_r = 8'(16'(lvl_r) << res_exponent) + half_step;
        ctr_g = 8'(16'(lvl_g) << res_exponent) + half_step;
        ctr_b = 8'(16'(lvl_b) << res_exponent) + half_step;
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            if (res_count == '0)
            begin
                m_tdata_next = '0;
            end
            else
            begin
                m_tdata_next = {24'(res_count), ctr_b, ctr_g, ctr_r};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/bchm_regs.sv
// configuration register file with exponent clamping and coordinate masking
module bchm_regs
    import bchm_pkg::*;
#(
    parameter int LEVEL_BITS  = 4,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [REG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    localparam logic [15:0] COORD_MASK =
        (COORD_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_WIDTH) - 32'd1);
    localparam logic [3:0] EXP_MIN = 4'(LEVEL_BITS);
    localparam logic [3:0] EXP_MAX = 4'(CHANNEL_BITS);

    logic [15:0] thickness_reg;
    logic [3:0]  exponent_reg;
    logic [15:0] left_reg;
    logic [15:0] top_reg;
    logic [15:0] right_reg;
    logic [15:0] bottom_reg;
    logic [2:0]  channels_reg;
    logic [3:0]  exp_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thickness_reg <= THICKNESS_RESET;
            exponent_reg  <= EXPONENT_RESET;
            left_reg      <= '0;
            top_reg       <= '0;
            right_reg     <= '0;
            bottom_reg    <= '0;
            channels_reg  <= CHANNELS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THICKNESS: thickness_reg <= cfg_data;
                REG_EXPONENT:  exponent_reg  <= cfg_data[3:0];
                REG_LEFT:      left_reg      <= cfg_data;
                REG_TOP:       top_reg       <= cfg_data;
                REG_RIGHT:     right_reg     <= cfg_data;
                REG_BOTTOM:    bottom_reg    <= cfg_data;
                REG_CHANNELS:  channels_reg  <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        exp_clamped = exponent_reg;
        if (exp_clamped < EXP_MIN)
        begin
            exp_clamped = EXP_MIN;
        end
        if (exp_clamped > EXP_MAX)
        begin
            exp_clamped = EXP_MAX;
        end
    end

    always_comb
    begin
        cfg.thickness  = thickness_reg;
        cfg.left_edge  = left_reg & COORD_MASK;
        cfg.top_edge   = top_reg & COORD_MASK;
        cfg.right_end  = right_reg & COORD_MASK;
        cfg.bottom_end = bottom_reg & COORD_MASK;
        cfg.exponent   = exp_clamped;
        cfg.level_bits = EXP_MAX - exp_clamped;
        cfg.use_green  = channels_reg > 3'd1;
        cfg.use_blue   = channels_reg > 3'd2;
    end

endmodule

FILE: src/bchm_binner.sv
// border band test and histogram cell address of one pixel
module bchm_binner
    import bchm_pkg::*;
#(
    parameter int LEVEL_BITS  = 4,
    parameter int COORD_WIDTH = 16
)
(
    input  cfg_t                          cfg,
    input  logic [15:0]                   pixel_x,
    input  logic [15:0]                   pixel_y,
    input  logic [CHANNEL_BITS-1:0]       red_in,
    input  logic [CHANNEL_BITS-1:0]       green_in,
    input  logic [CHANNEL_BITS-1:0]       blue_in,
    output logic                          hit,
    output logic [((3 * (CHANNEL_BITS - LEVEL_BITS)) > 0 ?
                   (3 * (CHANNEL_BITS - LEVEL_BITS)) : 1)-1:0] cell_addr
);

    localparam int CELL_BITS = 3 * (CHANNEL_BITS - LEVEL_BITS);
    localparam int ADDR_W    = (CELL_BITS > 0) ? CELL_BITS : 1;
    localparam logic [15:0] COORD_MASK =
        (COORD_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_WIDTH) - 32'd1);

    logic [15:0] x_m;
    logic [15:0] y_m;
    logic [16:0] x_low_lim;
    logic [16:0] y_low_lim;
    logic [16:0] x_high_lim;
    logic [16:0] y_high_lim;
    logic        near_left;
    logic        near_top;
    logic        near_right;
    logic        near_bottom;
    logic [CHANNEL_BITS-1:0] r_lvl;
    logic [CHANNEL_BITS-1:0] g_lvl;
    logic [CHANNEL_BITS-1:0] b_lvl;
    logic [23:0] cell_full;

    always_comb
    begin
        x_m = pixel_x & COORD_MASK;
        y_m = pixel_y & COORD_MASK;
        x_low_lim  = {1'b0, cfg.left_edge} + {1'b0, cfg.thickness};
        y_low_lim  = {1'b0, cfg.top_edge} + {1'b0, cfg.thickness};
        // a negative difference (top bit set) puts every pixel past the far edge
        x_high_lim = {1'b0, cfg.right_end} - {1'b0, cfg.thickness};
        y_high_lim = {1'b0, cfg.bottom_end} - {1'b0, cfg.thickness};
        near_left   = {1'b0, x_m} < x_low_lim;
        near_top    = {1'b0, y_m} < y_low_lim;
        near_right  = x_high_lim[16] || ({1'b0, x_m} >= x_high_lim);
        near_bottom = y_high_lim[16] || ({1'b0, y_m} >= y_high_lim);
        hit = near_left || near_top || near_right || near_bottom;
    end

    always_comb
    begin
        r_lvl = red_in >> cfg.exponent;
        g_lvl = cfg.use_green ? (green_in >> cfg.exponent) : '0;
        b_lvl = cfg.use_blue ? (blue_in >> cfg.exponent) : '0;
        cell_full = (24'(r_lvl) << {cfg.level_bits, 1'b0})
                  | (24'(g_lvl) << cfg.level_bits)
                  | 24'(b_lvl);
        cell_addr = (CELL_BITS > 0) ? cell_full[ADDR_W-1:0] : '0;
    end

endmodule

FILE: src/bchm_cube.sv
// histogram cube memory: counting read-modify-write, peak scan and clearing sweep
module bchm_cube
    import bchm_pkg::*;
#(
    parameter int LEVEL_BITS  = 4,
    parameter int COUNT_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   px_valid,
    output logic                   px_ready,
    input  logic                   px_hit,
    input  logic                   px_last,
    input  logic [((3 * (CHANNEL_BITS - LEVEL_BITS)) > 0 ?
                   (3 * (CHANNEL_BITS - LEVEL_BITS)) : 1)-1:0] px_cell,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [COUNT_WIDTH-1:0] res_count,
    output logic [((3 * (CHANNEL_BITS - LEVEL_BITS)) > 0 ?
                   (3 * (CHANNEL_BITS - LEVEL_BITS)) : 1)-1:0] res_index,
    output logic [3:0]             res_exponent,
    output logic [3:0]             res_level_bits
);

    localparam int CELL_BITS  = 3 * (CHANNEL_BITS - LEVEL_BITS);
    localparam int ADDR_W     = (CELL_BITS > 0) ? CELL_BITS : 1;
    localparam int CELL_TOTAL = 1 << CELL_BITS;
    localparam int CNT_W      = CELL_BITS + 1;
    localparam logic [CNT_W-1:0]       SCAN_END  = CNT_W'(CELL_TOTAL - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_COUNT = 5'b00010,
        ST_SWEEP = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0] mem [CELL_TOTAL];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    logic              s1_valid_reg;
    logic              s1_hit_reg;
    logic              s1_last_reg;
    logic [ADDR_W-1:0] s1_cell_reg;

    logic                   fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]      fwd_cell_reg;
    logic [COUNT_WIDTH-1:0] fwd_count_reg;

    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   cmp_valid_reg;
    logic [ADDR_W-1:0]      cmp_addr_reg;
    logic [COUNT_WIDTH-1:0] best_count_reg, best_count_next;
    logic [ADDR_W-1:0]      best_index_reg, best_index_next;
    logic [3:0]             exp_scan_reg;
    logic [3:0]             lvl_scan_reg;

    logic                   px_accept;
    logic                   count_write;
    logic [COUNT_WIDTH-1:0] base_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [4:0]             scope_shift;
    logic                   in_scope;

    assign px_ready  = (state_reg == ST_COUNT) && !(s1_valid_reg && s1_last_reg);
    assign px_accept = px_valid && px_ready;
    assign count_write = (state_reg == ST_COUNT) && s1_valid_reg && s1_hit_reg;

    // the write of the previous cycle is missed by this item's read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_cell_reg == s1_cell_reg))
        begin
            base_count = fwd_count_reg;
        end
        else
        begin
            base_count = rd_data_reg;
        end
        new_count = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = s1_cell_reg;
        mem_wdata = new_count;
        mem_re    = px_accept;
        mem_raddr = px_cell;
        if (count_write)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == ST_CLEAR) || (state_reg == ST_SWEEP))
        begin
            mem_we    = 1'b1;
            mem_waddr = scan_reg[ADDR_W-1:0];
            mem_wdata = '0;
        end
        if (state_reg == ST_SWEEP)
        begin
            mem_re    = 1'b1;
            mem_raddr = scan_reg[ADDR_W-1:0];
        end
    end

    // read returns the contents from before a write to the same entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign fwd_valid_next = count_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= px_accept;
            fwd_valid_reg <= fwd_valid_next;
            cmp_valid_reg <= (state_reg == ST_SWEEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (px_accept)
        begin
            s1_hit_reg  <= px_hit;
            s1_last_reg <= px_last;
            s1_cell_reg <= px_cell;
        end
        fwd_cell_reg  <= s1_cell_reg;
        fwd_count_reg <= new_count;
        cmp_addr_reg  <= scan_reg[ADDR_W-1:0];
    end

    // only cells reachable under the scan exponent compete
    always_comb
    begin
        scope_shift = 5'({lvl_scan_reg, 1'b0}) + 5'(lvl_scan_reg);
        in_scope    = ((32'(cmp_addr_reg) >> scope_shift) == 32'd0);
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        best_count_next = best_count_reg;
        best_index_next = best_index_reg;
        if (cmp_valid_reg && in_scope && (rd_data_reg > best_count_reg))
        begin
            best_count_next = rd_data_reg;
            best_index_next = cmp_addr_reg;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_END)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next      = ST_SWEEP;
                    scan_next       = '0;
                    best_count_next = '0;
                    best_index_next = '0;
                end
            end
            ST_SWEEP:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_END)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_COUNT;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_reg       <= '0;
            best_count_reg <= '0;
            best_index_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            best_count_reg <= best_count_next;
            best_index_reg <= best_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_COUNT) && s1_valid_reg && s1_last_reg)
        begin
            exp_scan_reg <= cfg.exponent;
            lvl_scan_reg <= cfg.level_bits;
        end
    end

    assign res_valid      = (state_reg == ST_DONE);
    assign res_count      = best_count_reg;
    assign res_index      = best_index_reg;
    assign res_exponent   = exp_scan_reg;
    assign res_level_bits = lvl_scan_reg;

    a_last_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT && s1_valid_reg && s1_last_reg) |=> (state_reg == ST_SWEEP))
        else $error("last pixel did not start the scan");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SWEEP || state_reg == ST_DRAIN) && $past(state_reg == ST_SWEEP))
        |-> (best_count_reg >= $past(best_count_reg)))
        else $error("peak count fell during the scan");

    a_forward_source: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> $past(count_write))
        else $error("forwarding without a preceding count write");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(best_count_reg)
        && $stable(best_index_reg)))
        else $error("result changed before it was taken");

endmodule
